### rtl/cfsd_pkg.sv
// Shared constants, types and result codes for the comb filter synchronous detector.
// No dependencies; every other file in rtl/ imports this package.
package cfsd_pkg;

    // Converter and filter widths
    localparam int SAMPLE_BITS = 12;
    localparam int COMB_W      = SAMPLE_BITS + 1;
    localparam int CASC_W      = SAMPLE_BITS + 2;
    localparam int SUM_W       = 18;
    localparam int TOTAL_W     = 32;
    localparam int VALUE_W     = 33;
    localparam int INDEX_W     = 3;

    // Frame and delay geometry
    localparam int FRAME_LEN   = 120;
    localparam int FPOS_W      = $clog2(FRAME_LEN);
    localparam int LONG_DELAY  = 30;
    localparam int SHORT_DELAY = 25;
    localparam int CHAIN_LEN   = (LONG_DELAY > SHORT_DELAY) ? LONG_DELAY : SHORT_DELAY;

    // Detector banks
    localparam int NUM_P10     = 5;
    localparam int NUM_P12     = 6;
    localparam int NUM_CHAN    = 3;
    localparam int PHASE_W     = 4;

    // Result sequence of one item: sample, five period-10, six period-12, three totals
    localparam int SEQ_W        = 4;
    localparam int SEQ_P10_BASE = 1;
    localparam int SEQ_P12_BASE = SEQ_P10_BASE + NUM_P10;
    localparam int SEQ_TOT_BASE = SEQ_P12_BASE + NUM_P12;
    localparam int LAST_SEQ     = SEQ_TOT_BASE + NUM_CHAN - 1;

    // Stream packing
    localparam int S_TDATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_FIELD_W = INDEX_W + VALUE_W + 2 * COMB_W + CASC_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_PERIOD10 = 2'd1,
        KIND_PERIOD12 = 2'd2,
        KIND_TOTAL   = 2'd3
    } kind_t;

    // Read and clear request from the output sequencer to the detector
    typedef struct packed {
        logic               active;
        kind_t              kind;
        logic [INDEX_W-1:0] idx;
    } rd_t;

endpackage

### rtl/cfsd_cell.sv
// One cell of the channel A delay chain: holds a raw sample and a 25-comb value.
// Depends on cfsd_pkg for widths.
module cfsd_cell
    import cfsd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  logic [SAMPLE_BITS-1:0] raw_in,
    input  logic [COMB_W-1:0]      comb_in,
    output logic [SAMPLE_BITS-1:0] raw_out,
    output logic [COMB_W-1:0]      comb_out
);

    logic [SAMPLE_BITS-1:0] raw_reg;
    logic [COMB_W-1:0]      comb_reg;

    // Take the neighbor's values on every accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg  <= '0;
            comb_reg <= '0;
        end else if (shift_en) begin
            raw_reg  <= raw_in;
            comb_reg <= comb_in;
        end
    end

    assign raw_out  = raw_reg;
    assign comb_out = comb_reg;

endmodule

### rtl/cfsd_detect.sv
// Frame counter, square-wave detector accumulators and channel totals.
// Depends on cfsd_pkg; the sequencer reads sums one at a time, clearing all but totals.
module cfsd_detect
    import cfsd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [SAMPLE_BITS-1:0] sample_a,
    input  logic [SAMPLE_BITS-1:0] sample_b,
    input  logic [SAMPLE_BITS-1:0] sample_c,
    input  logic [COMB_W-1:0]      comb_thirty,
    input  logic [COMB_W-1:0]      comb_twentyfive,
    input  rd_t                    rd,
    output logic                   frame_end,
    output logic [VALUE_W-1:0]     rd_value
);

    logic [FPOS_W-1:0]  frame_pos_reg, frame_pos_next;
    logic [PHASE_W-1:0] p10_reg, p10_next;
    logic [PHASE_W-1:0] p12_reg, p12_next;
    logic [SUM_W-1:0]   sum10_reg [NUM_P10];
    logic [SUM_W-1:0]   sum10_next[NUM_P10];
    logic [SUM_W-1:0]   sum12_reg [NUM_P12];
    logic [SUM_W-1:0]   sum12_next[NUM_P12];
    logic [TOTAL_W-1:0] total_reg [NUM_CHAN];
    logic [TOTAL_W-1:0] total_next[NUM_CHAN];

    logic [PHASE_W-1:0] p10_hi;
    logic [PHASE_W-1:0] p12_hi;
    logic [SUM_W-1:0]   c30_ext;
    logic [SUM_W-1:0]   c25_ext;

    assign frame_end = frame_pos_reg >= FPOS_W'(FRAME_LEN - 1);
    assign p10_hi    = p10_reg - PHASE_W'(NUM_P10);
    assign p12_hi    = p12_reg - PHASE_W'(NUM_P12);
    assign c30_ext   = SUM_W'(comb_thirty);
    assign c25_ext   = SUM_W'(comb_twentyfive);

    // Advance frame position and the two phase counters
    always_comb begin
        frame_pos_next = frame_pos_reg;
        p10_next       = p10_reg;
        p12_next       = p12_reg;
        if (accept) begin
            if (frame_end) begin
                frame_pos_next = '0;
                p10_next       = '0;
                p12_next       = '0;
            end else begin
                frame_pos_next = frame_pos_reg + 1'b1;
                p10_next = (p10_reg == PHASE_W'(2 * NUM_P10 - 1)) ? '0 : p10_reg + 1'b1;
                p12_next = (p12_reg == PHASE_W'(2 * NUM_P12 - 1)) ? '0 : p12_reg + 1'b1;
            end
        end
    end

    // Accumulate on accept; clear a sum once the sequencer has taken it
    always_comb begin
        sum10_next = sum10_reg;
        sum12_next = sum12_reg;
        total_next = total_reg;
        if (accept) begin
            if (p10_reg < PHASE_W'(NUM_P10)) begin
                sum10_next[p10_reg[INDEX_W-1:0]] = sum10_reg[p10_reg[INDEX_W-1:0]] - c30_ext;
            end else begin
                sum10_next[p10_hi[INDEX_W-1:0]] = sum10_reg[p10_hi[INDEX_W-1:0]] + c30_ext;
            end
            if (p12_reg < PHASE_W'(NUM_P12)) begin
                sum12_next[p12_reg[INDEX_W-1:0]] = sum12_reg[p12_reg[INDEX_W-1:0]] - c25_ext;
            end else begin
                sum12_next[p12_hi[INDEX_W-1:0]] = sum12_reg[p12_hi[INDEX_W-1:0]] + c25_ext;
            end
            total_next[0] = total_reg[0] + TOTAL_W'(sample_a);
            total_next[1] = total_reg[1] + TOTAL_W'(sample_b);
            total_next[2] = total_reg[2] + TOTAL_W'(sample_c);
        end
        if (rd.active && rd.kind == KIND_PERIOD10) begin
            sum10_next[rd.idx] = '0;
        end
        if (rd.active && rd.kind == KIND_PERIOD12) begin
            sum12_next[rd.idx] = '0;
        end
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos_reg <= '0;
            p10_reg       <= '0;
            p12_reg       <= '0;
            for (int i = 0; i < NUM_P10; i++) sum10_reg[i] <= '0;
            for (int i = 0; i < NUM_P12; i++) sum12_reg[i] <= '0;
            for (int i = 0; i < NUM_CHAN; i++) total_reg[i] <= '0;
        end else begin
            frame_pos_reg <= frame_pos_next;
            p10_reg       <= p10_next;
            p12_reg       <= p12_next;
            sum10_reg     <= sum10_next;
            sum12_reg     <= sum12_next;
            total_reg     <= total_next;
        end
    end

    // Select the sum the sequencer asks for; detector sums sign-extend
    always_comb begin
        unique case (rd.kind)
            KIND_PERIOD10: rd_value = {{(VALUE_W - SUM_W){sum10_reg[rd.idx][SUM_W-1]}},
                                       sum10_reg[rd.idx]};
            KIND_PERIOD12: rd_value = {{(VALUE_W - SUM_W){sum12_reg[rd.idx][SUM_W-1]}},
                                       sum12_reg[rd.idx]};
            KIND_TOTAL:    rd_value = VALUE_W'(total_reg[rd.idx[1:0]]);
            default:       rd_value = '0;
        endcase
    end

endmodule

### rtl/comb_filter_sync_detector.sv
// Top level of the comb filter synchronous detector: delay chain, detector, result sequencer.
// Depends on cfsd_pkg, cfsd_cell and cfsd_detect.
//
// Usage:
//   s_ channel: one item per converter triple (samples A, B, C in s_tdata).
//   m_ channel: result items. Every input item gives one filtered-sample item
//   (kind 0 in m_tuser) carrying the three comb outputs. The last item of a
//   120-item frame adds five period-10 sums, six period-12 sums and three
//   channel totals; m_tlast marks the final result of each input item.
//   The sample result of an item passes the sequencer slot, then the output register.
//   Throughput: one item per cycle while the receiver takes results; a
//   frame-ending item holds the single result-sequencer slot until its last result
//   is out, so s_tready drops once per frame. The sequencer emits one result
//   per cycle while the output register is free; it and the receiver limit the rate.
//   Reset (aresetn low, synchronous): delay lines, sums, totals and the frame
//   position clear to zero; no result is pending.
//   Receiver stall: the output register holds its item while m_tready is low;
//   one more item is taken into the sequencer slot, then s_tready drops.
module comb_filter_sync_detector
    import cfsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // sample_a [11:0], sample_b [23:12], sample_c [35:24], zero fill to 40
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // index [2:0], value [35:3], comb_thirty [48:36], comb_twentyfive [61:49],
    // comb_cascade [75:62], zero fill to 80
    output logic [M_TDATA_W-1:0] m_tdata,
    // kind [1:0]
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    logic [SAMPLE_BITS-1:0] sample_a, sample_b, sample_c;
    logic                   accept;

    assign sample_a = s_tdata[SAMPLE_BITS-1:0];
    assign sample_b = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign sample_c = s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign accept   = s_tvalid && s_tready;

    // Delay chain of cells
    logic [SAMPLE_BITS-1:0] raw_tap [CHAIN_LEN];
    logic [COMB_W-1:0]      comb_tap[CHAIN_LEN];
    logic [COMB_W-1:0]      c30, c25;
    logic [CASC_W-1:0]      casc;

    assign c30  = COMB_W'(sample_a) + COMB_W'(raw_tap[LONG_DELAY-1]);
    assign c25  = COMB_W'(sample_a) + COMB_W'(raw_tap[SHORT_DELAY-1]);
    assign casc = CASC_W'(c25) + CASC_W'(comb_tap[LONG_DELAY-1]);

    for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
        if (k == 0) begin : g_head
            cfsd_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (accept),
                .raw_in   (sample_a),
                .comb_in  (c25),
                .raw_out  (raw_tap[k]),
                .comb_out (comb_tap[k])
            );
        end else begin : g_body
            cfsd_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (accept),
                .raw_in   (raw_tap[k-1]),
                .comb_in  (comb_tap[k-1]),
                .raw_out  (raw_tap[k]),
                .comb_out (comb_tap[k])
            );
        end
    end

    // Detector
    rd_t                rd;
    logic               frame_end;
    logic [VALUE_W-1:0] rd_value;

    cfsd_detect u_detect (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .sample_a        (sample_a),
        .sample_b        (sample_b),
        .sample_c        (sample_c),
        .comb_thirty     (c30),
        .comb_twentyfive (c25),
        .rd              (rd),
        .frame_end       (frame_end),
        .rd_value        (rd_value)
    );

    // Sequencer slot: one item's results, one per cycle while the output register can take them
    logic               job_valid_reg;
    logic               job_end_reg;
    logic [COMB_W-1:0]  job_c30_reg, job_c25_reg;
    logic [CASC_W-1:0]  job_casc_reg;
    logic [SEQ_W-1:0]   seq_reg;

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]         m_tuser_reg;
    logic               m_tlast_reg;

    logic               out_load, move, job_done;
    kind_t              res_kind;
    logic [SEQ_W-1:0]   res_off;
    logic               res_last;
    logic [VALUE_W-1:0] res_value;

    assign out_load = !m_tvalid_reg || m_tready;
    assign move     = job_valid_reg && out_load;
    assign job_done = move && (seq_reg == SEQ_W'(LAST_SEQ) || (seq_reg == '0 && !job_end_reg));
    assign s_tready = !job_valid_reg || job_done;

    // Decode the current result from the sequence count
    always_comb begin
        res_off  = '0;
        res_last = 1'b0;
        if (seq_reg == '0) begin
            res_kind = KIND_SAMPLE;
            res_last = !job_end_reg;
        end else if (seq_reg < SEQ_W'(SEQ_P12_BASE)) begin
            res_kind = KIND_PERIOD10;
            res_off  = seq_reg - SEQ_W'(SEQ_P10_BASE);
        end else if (seq_reg < SEQ_W'(SEQ_TOT_BASE)) begin
            res_kind = KIND_PERIOD12;
            res_off  = seq_reg - SEQ_W'(SEQ_P12_BASE);
        end else begin
            res_kind = KIND_TOTAL;
            res_off  = seq_reg - SEQ_W'(SEQ_TOT_BASE);
            res_last = seq_reg == SEQ_W'(LAST_SEQ);
        end
    end

    assign rd.active = move;
    assign rd.kind   = res_kind;
    assign rd.idx    = res_off[INDEX_W-1:0];
    assign res_value = (res_kind == KIND_SAMPLE) ? '0 : rd_value;

    // Load a new item into the slot, or step through its results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            job_end_reg   <= 1'b0;
            seq_reg       <= '0;
        end else if (accept) begin
            job_valid_reg <= 1'b1;
            job_end_reg   <= frame_end;
            seq_reg       <= '0;
        end else if (job_done) begin
            job_valid_reg <= 1'b0;
            seq_reg       <= '0;
        end else if (move) begin
            seq_reg <= seq_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_c30_reg  <= c30;
            job_c25_reg  <= c25;
            job_casc_reg <= casc;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (move) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_tuser_reg <= res_kind;
            m_tlast_reg <= res_last;
            if (res_kind == KIND_SAMPLE) begin
                m_tdata_reg <= M_TDATA_W'({job_casc_reg, job_c25_reg, job_c30_reg,
                                           res_value, res_off[INDEX_W-1:0]});
            end else begin
                m_tdata_reg <= M_TDATA_W'({(2 * COMB_W + CASC_W)'(0),
                                           res_value, res_off[INDEX_W-1:0]});
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    a_frame_job: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && frame_end |=> job_valid_reg && job_end_reg)
        else $error("frame-ending item not loaded as a burst job");

    a_seq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg <= SEQ_W'(LAST_SEQ))
        else $error("result sequence count out of range");

    a_seq_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg != '0 |-> job_valid_reg && job_end_reg)
        else $error("sum results sequenced outside a frame-ending item");

    a_total_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_TOTAL && m_tdata[INDEX_W-1:0] == INDEX_W'(NUM_CHAN - 1)
        |-> m_tlast)
        else $error("last channel total not marked last");

endmodule
